// ===== rtl/core/lspr_pkg.sv =====
// Shared types and constants for the laser scan point rasterizer core.
// No dependencies; imported by every module of the core.
package lspr_pkg;

  typedef struct packed {
    logic signed [15:0] angle_start;
    logic [15:0]        angle_step;
    logic [15:0]        range_floor;
    logic [15:0]        range_ceiling;
    logic [9:0]         ppm;
    logic [11:0]        sample_count;
  } lspr_cfg_t;

  localparam logic [2:0] REG_ANGLE_START   = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP    = 3'd1;
  localparam logic [2:0] REG_RANGE_FLOOR   = 3'd2;
  localparam logic [2:0] REG_RANGE_CEILING = 3'd3;
  localparam logic [2:0] REG_PPM           = 3'd4;
  localparam logic [2:0] REG_SAMPLE_COUNT  = 3'd5;

  localparam int CORDIC_STAGES = 16;
  localparam int XYW = 34;
  localparam int ZW  = 26;
  localparam logic signed [XYW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [ZW-1:0]  QUARTER_TURN = 26'sd4194304;
  localparam logic signed [ZW-1:0]  HALF_TURN    = 26'sd8388608;

  // floor(u / 125) = (u * RECIP_M) >> RECIP_SHIFT for u below 2^24
  localparam logic [24:0] RECIP_M = 25'd17179870;
  localparam int RECIP_SHIFT = 31;
  localparam int DIV_SHIFT   = 18;
  localparam int CW = 13;
  localparam int ADDR_CALC_W = 24;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 26'sd2097152;
      1:  v = 26'sd1238021;
      2:  v = 26'sd654136;
      3:  v = 26'sd332050;
      4:  v = 26'sd166669;
      5:  v = 26'sd83416;
      6:  v = 26'sd41718;
      7:  v = 26'sd20860;
      8:  v = 26'sd10430;
      9:  v = 26'sd5215;
      10: v = 26'sd2608;
      11: v = 26'sd1304;
      12: v = 26'sd652;
      13: v = 26'sd326;
      14: v = 26'sd163;
      default: v = 26'sd81;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/lspr_front.sv =====
// Front end: index check, range clamp, beam angle and quadrant fold.
// Depends on lspr_pkg.
module lspr_front import lspr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  lspr_cfg_t            cfg,
  input  logic                 in_valid,
  input  logic [11:0]          in_sample_index,
  input  logic [15:0]          in_range_mm,
  output logic                 v_o,
  output logic [15:0]          r_o,
  output logic signed [ZW-1:0] z_o,
  output logic                 flip_o
);

  logic        v1_r;
  logic [15:0] r1_r;
  logic [27:0] prod1_r;
  logic [15:0] rfl;
  logic [15:0] rcl;

  always_comb begin
    rfl = (in_range_mm < cfg.range_floor) ? cfg.range_floor : in_range_mm;
    rcl = (rfl > cfg.range_ceiling) ? cfg.range_ceiling : rfl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid && (in_sample_index < cfg.sample_count);
    end
    if (adv) begin
      r1_r    <= rcl;
      prod1_r <= 28'(in_sample_index) * 28'(cfg.angle_step);
    end
  end

  logic [15:0]          angle;
  logic signed [ZW-1:0] z0;
  logic signed [ZW-1:0] zf;
  logic                 flip;

  always_comb begin
    angle = cfg.angle_start + prod1_r[15:0];
    z0    = {{2{angle[15]}}, angle, 8'b0};
    zf    = z0;
    flip  = 1'b0;
    if (z0 > QUARTER_TURN) begin
      zf   = z0 - HALF_TURN;
      flip = 1'b1;
    end else if (z0 < -QUARTER_TURN) begin
      zf   = z0 + HALF_TURN;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (adv) begin
      v_o <= v1_r;
    end
    if (adv) begin
      r_o    <= r1_r;
      z_o    <= zf;
      flip_o <= flip;
    end
  end

endmodule

// ===== rtl/core/lspr_cordic.sv =====
// Rotation CORDIC, one micro-rotation per register stage.
// Depends on lspr_pkg for widths and the arctangent table.
module lspr_cordic import lspr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  v_i,
  input  logic [15:0]           r_i,
  input  logic signed [ZW-1:0]  z_i,
  input  logic                  flip_i,
  output logic                  v_o,
  output logic [15:0]           r_o,
  output logic signed [XYW-1:0] x_o,
  output logic signed [XYW-1:0] y_o,
  output logic                  flip_o
);

  logic                  va [0:CORDIC_STAGES];
  logic [15:0]           ra [0:CORDIC_STAGES];
  logic signed [XYW-1:0] xa [0:CORDIC_STAGES];
  logic signed [XYW-1:0] ya [0:CORDIC_STAGES];
  logic signed [ZW-1:0]  za [0:CORDIC_STAGES];
  logic                  fa [0:CORDIC_STAGES];

  assign va[0] = v_i;
  assign ra[0] = r_i;
  assign xa[0] = CORDIC_X0;
  assign ya[0] = '0;
  assign za[0] = z_i;
  assign fa[0] = flip_i;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic                  v_r;
    logic [15:0]           r_r;
    logic signed [XYW-1:0] x_r;
    logic signed [XYW-1:0] y_r;
    logic signed [ZW-1:0]  z_r;
    logic                  f_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= va[i];
      end
      if (adv) begin
        r_r <= ra[i];
        f_r <= fa[i];
        if (!za[i][ZW-1]) begin
          x_r <= xa[i] - (ya[i] >>> i);
          y_r <= ya[i] + (xa[i] >>> i);
          z_r <= za[i] - atan_turn(i);
        end else begin
          x_r <= xa[i] + (ya[i] >>> i);
          y_r <= ya[i] - (xa[i] >>> i);
          z_r <= za[i] + atan_turn(i);
        end
      end
    end

    assign va[i+1] = v_r;
    assign ra[i+1] = r_r;
    assign xa[i+1] = x_r;
    assign ya[i+1] = y_r;
    assign za[i+1] = z_r;
    assign fa[i+1] = f_r;
  end

  // final angle residue is not needed downstream
  logic z_unused;
  assign z_unused = ^za[CORDIC_STAGES];

  assign v_o    = va[CORDIC_STAGES] & (z_unused | ~z_unused);
  assign r_o    = ra[CORDIC_STAGES];
  assign x_o    = xa[CORDIC_STAGES];
  assign y_o    = ya[CORDIC_STAGES];
  assign flip_o = fa[CORDIC_STAGES];

endmodule

// ===== rtl/core/lspr_scale.sv =====
// Back end: Q1.15 rounding, range and scale products, division by the
// metre constant, image clamp and pixel address. Depends on lspr_pkg.
module lspr_scale import lspr_pkg::*; #(
  parameter int IMAGE_WIDTH  = 500,
  parameter int IMAGE_HEIGHT = 500
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [9:0]            ppm,
  input  logic                  v_i,
  input  logic [15:0]           r_i,
  input  logic signed [XYW-1:0] x_i,
  input  logic signed [XYW-1:0] y_i,
  input  logic                  flip_i,
  output logic                  out_valid,
  output logic [8:0]            out_pixel_x,
  output logic [8:0]            out_pixel_y,
  output logic [17:0]           out_pixel_address
);

  function automatic logic signed [15:0] to_q15(input logic signed [XYW-1:0] v);
    logic signed [XYW-1:0] t;
    t = (v + XYW'(16384)) >>> 15;
    if (t > XYW'(32767))       return 16'sh7FFF;
    else if (t < -XYW'(32768)) return 16'sh8000;
    else                       return t[15:0];
  endfunction

  // stage 1: undo fold, round to Q1.15
  logic                  v1_r;
  logic [15:0]           r1_r;
  logic signed [15:0]    c1_r, s1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= v_i;
    if (adv) begin
      r1_r <= r_i;
      c1_r <= to_q15(flip_i ? -x_i : x_i);
      s1_r <= to_q15(flip_i ? -y_i : y_i);
    end
  end

  // stage 2: range times trig
  logic               v2_r;
  logic signed [32:0] rc2_r, rs2_r;
  logic signed [32:0] rs_ext;
  assign rs_ext = 33'($signed({1'b0, r1_r}));
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      rc2_r <= rs_ext * 33'(c1_r);
      rs2_r <= rs_ext * 33'(s1_r);
    end
  end

  // stage 3: times scale; y points up, so negate its product
  logic               v3_r;
  logic signed [43:0] px3_r, py3_r;
  logic signed [43:0] ppm_ext;
  assign ppm_ext = 44'($signed({1'b0, ppm}));
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      px3_r <= 44'(rc2_r) * ppm_ext;
      py3_r <= -(44'(rs2_r) * ppm_ext);
    end
  end

  // stage 4: drop the power-of-two part of the divisor, fold sign
  logic        v4_r;
  logic [24:0] ux4_r, uy4_r;
  logic        nx4_r, ny4_r;
  logic [25:0] tx, ty;
  assign tx = px3_r[43:DIV_SHIFT];
  assign ty = py3_r[43:DIV_SHIFT];
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
    if (adv) begin
      nx4_r <= tx[25];
      ny4_r <= ty[25];
      ux4_r <= tx[25] ? ~tx[24:0] : tx[24:0];
      uy4_r <= ty[25] ? ~ty[24:0] : ty[24:0];
    end
  end

  // stage 5: divide by 125 through the reciprocal
  logic        v5_r;
  logic [49:0] mx, my;
  logic [18:0] qx5_r, qy5_r;
  logic        nx5_r, ny5_r;
  assign mx = 50'(ux4_r) * 50'(RECIP_M);
  assign my = 50'(uy4_r) * 50'(RECIP_M);
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
    if (adv) begin
      qx5_r <= mx[RECIP_SHIFT +: 19];
      qy5_r <= my[RECIP_SHIFT +: 19];
      nx5_r <= nx4_r;
      ny5_r <= ny4_r;
    end
  end

  // stage 6: restore sign, offset from image centre, clamp
  localparam logic signed [20:0] HALF_W = 21'(IMAGE_WIDTH / 2);
  localparam logic signed [20:0] HALF_H = 21'(IMAGE_HEIGHT / 2);
  localparam logic signed [20:0] MAX_W  = 21'(IMAGE_WIDTH - 1);
  localparam logic signed [20:0] MAX_H  = 21'(IMAGE_HEIGHT - 1);

  logic signed [19:0] qx, qy;
  logic signed [20:0] sx, sy;
  logic [CW-1:0]      cx, cy;
  logic               v6_r;
  logic [CW-1:0]      x6_r, y6_r;

  always_comb begin
    qx = nx5_r ? ~{1'b0, qx5_r} : {1'b0, qx5_r};
    qy = ny5_r ? ~{1'b0, qy5_r} : {1'b0, qy5_r};
    sx = HALF_W + 21'(qx);
    sy = HALF_H + 21'(qy);
    if (sx < 0)          cx = '0;
    else if (sx > MAX_W) cx = MAX_W[CW-1:0];
    else                 cx = sx[CW-1:0];
    if (sy < 0)          cy = '0;
    else if (sy > MAX_H) cy = MAX_H[CW-1:0];
    else                 cy = sy[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
    if (adv) begin
      x6_r <= cx;
      y6_r <= cy;
    end
  end

  // stage 7: pixel address into the output register
  logic [ADDR_CALC_W-1:0] addr;
  assign addr = ADDR_CALC_W'(y6_r) * ADDR_CALC_W'(IMAGE_WIDTH) + ADDR_CALC_W'(x6_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= v6_r;
    if (adv) begin
      out_pixel_x       <= 9'(x6_r);
      out_pixel_y       <= 9'(y6_r);
      out_pixel_address <= addr[17:0];
    end
  end

endmodule

// ===== rtl/core/laser_scan_point_rasterizer_core.sv =====
// Laser scan point rasterizer: range sample and beam index in, pixel out.
// Stages from input transfer to result: 2 front, 16 CORDIC, 7 back.
// Throughput: one sample per cycle; every stage is a register and the whole
// pipe holds together when the result register waits on out_ready.
// Reset (rst_n low, synchronous) clears all stage valid bits and loads the
// register defaults; samples past sample_count leave no result.
module laser_scan_point_rasterizer_core import lspr_pkg::*; #(
  parameter int IMAGE_WIDTH  = 500,
  parameter int IMAGE_HEIGHT = 500
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_sample_index,
  input  logic [15:0] in_range_mm,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  out_pixel_x,
  output logic [8:0]  out_pixel_y,
  output logic [17:0] out_pixel_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lspr_cfg_t cfg_r;
  logic      adv;

  // Advance the whole pipe whenever the result register is free or being
  // drained this cycle; otherwise hold every stage.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_start   <= 16'sd0;
      cfg_r.angle_step    <= 16'd182;
      cfg_r.range_floor   <= 16'd0;
      cfg_r.range_ceiling <= 16'd65535;
      cfg_r.ppm           <= 10'd50;
      cfg_r.sample_count  <= 12'd360;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ANGLE_START:   cfg_r.angle_start   <= cfg_data;
        REG_ANGLE_STEP:    cfg_r.angle_step    <= cfg_data;
        REG_RANGE_FLOOR:   cfg_r.range_floor   <= cfg_data;
        REG_RANGE_CEILING: cfg_r.range_ceiling <= cfg_data;
        REG_PPM:           cfg_r.ppm           <= cfg_data[9:0];
        REG_SAMPLE_COUNT:  cfg_r.sample_count  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic                  f_v, f_flip;
  logic [15:0]           f_r;
  logic signed [ZW-1:0]  f_z;

  // Gate the transfer: a sample only enters when the pipe advances.
  lspr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_sample_index (in_sample_index),
    .in_range_mm     (in_range_mm),
    .v_o             (f_v),
    .r_o             (f_r),
    .z_o             (f_z),
    .flip_o          (f_flip)
  );

  logic                  c_v, c_flip;
  logic [15:0]           c_r;
  logic signed [XYW-1:0] c_x, c_y;

  lspr_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .v_i    (f_v),
    .r_i    (f_r),
    .z_i    (f_z),
    .flip_i (f_flip),
    .v_o    (c_v),
    .r_o    (c_r),
    .x_o    (c_x),
    .y_o    (c_y),
    .flip_o (c_flip)
  );

  lspr_scale #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_scale (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .ppm               (cfg_r.ppm),
    .v_i               (c_v),
    .r_i               (c_r),
    .x_i               (c_x),
    .y_i               (c_y),
    .flip_i            (c_flip),
    .out_valid         (out_valid),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address)
  );

endmodule
